// ===== rtl/core/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define TCT_ASSERT(name, clock, reset, prop, msg) \
  name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define TCT_ASSERT_ALWAYS(name, clock, prop, msg) \
  name: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/core/tct_pkg.sv =====
package tct_pkg;

  localparam logic [7:0] CHAR_BS    = 8'd8;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] BLANK_CHAR = 8'h20;
  localparam logic [7:0] RESET_ATTR = 8'h07;
  localparam int         TAB_STOP   = 8;

  typedef enum logic [1:0] {
    OP_TTY    = 2'd0,
    OP_PUT_AT = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    K_TTY_CHAR,
    K_BACKSPACE,
    K_NEWLINE,
    K_RETURN,
    K_TAB,
    K_PUT_AT,
    K_CLEAR,
    K_READ
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] char_code;
    logic [4:0] row_sel;
    logic [6:0] col_sel;
    logic       on_screen;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_SCROLL,
    ST_FILL,
    ST_POST
  } state_t;

endpackage

// ===== rtl/core/tct_front.sv =====
module tct_front #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic          enable,
  input  logic          full,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [23:0]   s_tdata,
  output logic          push,
  output tct_pkg::cmd_t cmd
);
  import tct_pkg::*;

  op_t        opcode;
  logic [7:0] char_code;
  logic [4:0] row_select;
  logic [6:0] column_select;

  assign opcode        = op_t'(s_tdata[1:0]);
  assign char_code     = s_tdata[9:2];
  assign row_select    = s_tdata[14:10];
  assign column_select = s_tdata[21:15];

  assign s_tready = enable && !full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    cmd.char_code = char_code;
    cmd.row_sel   = row_select;
    cmd.col_sel   = column_select;
    cmd.on_screen = ({1'b0, row_select} < 6'(SCREEN_ROWS)) &&
                    ({1'b0, column_select} < 8'(SCREEN_COLUMNS));
    case (opcode)
      OP_TTY: begin
        case (char_code)
          CHAR_BS:  cmd.kind = K_BACKSPACE;
          CHAR_LF:  cmd.kind = K_NEWLINE;
          CHAR_CR:  cmd.kind = K_RETURN;
          CHAR_TAB: cmd.kind = K_TAB;
          default:  cmd.kind = K_TTY_CHAR;
        endcase
      end
      OP_PUT_AT: cmd.kind = K_PUT_AT;
      OP_CLEAR:  cmd.kind = K_CLEAR;
      default:   cmd.kind = K_READ;
    endcase
  end

endmodule

// ===== rtl/core/tct_queue.sv =====
module tct_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tct_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          cmd_valid,
  output tct_pkg::cmd_t cmd
);
  import tct_pkg::*;

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  cmd_t             entries [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [PTR_W:0]   count;

  assign full      = (count == (PTR_W + 1)'(DEPTH));
  assign cmd_valid = (count != '0);
  assign cmd       = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + 1'b1;
      end
      if (pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/tct_back.sv =====
`include "assert_macros.svh"

module tct_back #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [7:0]    cfg_wdata,
  input  logic          cmd_valid,
  input  tct_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          accepting,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [10:0]   cursor_position,
  output logic [15:0]   cell_data
);
  import tct_pkg::*;

  localparam int CELLS     = SCREEN_ROWS * SCREEN_COLUMNS;
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int POS_W     = (ADDR_W > 11) ? ADDR_W : 11;
  localparam int LAST_COPY = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;

  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(SCREEN_COLUMNS);
  localparam logic [ADDR_W-1:0] COPY_END_A = ADDR_W'(LAST_COPY);
  localparam logic [ADDR_W-1:0] LAST_A     = ADDR_W'(CELLS - 1);

  logic [15:0] mem [CELLS];
  logic [15:0] rd_data;

  state_t            state, state_next;
  logic [4:0]        cur_row, cur_row_next;
  logic [6:0]        cur_col, cur_col_next;
  logic [ADDR_W-1:0] cnt, cnt_next;
  logic [ADDR_W-1:0] wr_addr, wr_addr_next;
  logic              wr_pend, wr_pend_next;
  logic              data_sel, data_sel_next;
  logic [7:0]        attr;
  logic              res_valid;
  logic [10:0]       res_pos;
  logic [15:0]       res_data;
  logic              post;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0]       mem_wdata;
  logic              mem_re;
  logic [ADDR_W-1:0] mem_raddr;

  logic [POS_W-1:0]  cur_lin;
  logic [POS_W-1:0]  sel_lin;
  logic [POS_W-1:0]  bs_lin;
  logic [4:0]        bs_row;
  logic [6:0]        bs_col;
  logic [7:0]        adv_col;
  logic [5:0]        adv_row;

  assign cur_lin = POS_W'(cur_row) * POS_W'(SCREEN_COLUMNS) + POS_W'(cur_col);
  assign sel_lin = POS_W'(cmd.row_sel) * POS_W'(SCREEN_COLUMNS) + POS_W'(cmd.col_sel);
  assign bs_lin  = POS_W'(bs_row) * POS_W'(SCREEN_COLUMNS) + POS_W'(bs_col);

  always_comb begin
    bs_row = cur_row;
    bs_col = cur_col;
    if (cur_col != '0) begin
      bs_col = cur_col - 1'b1;
    end else if (cur_row != '0) begin
      bs_row = cur_row - 1'b1;
      bs_col = 7'(SCREEN_COLUMNS - 1);
    end
  end

  always_comb begin
    adv_col = {1'b0, cur_col};
    adv_row = {1'b0, cur_row};
    case (cmd.kind)
      K_TTY_CHAR: adv_col = {1'b0, cur_col} + 8'd1;
      K_NEWLINE: begin
        adv_col = '0;
        adv_row = {1'b0, cur_row} + 6'd1;
      end
      K_RETURN:   adv_col = '0;
      K_TAB:      adv_col = ({1'b0, cur_col} + 8'(TAB_STOP)) & ~8'(TAB_STOP - 1);
      default:    adv_col = {1'b0, cur_col};
    endcase
    if (adv_col >= 8'(SCREEN_COLUMNS)) begin
      adv_col = '0;
      adv_row = adv_row + 6'd1;
    end
  end

  assign accepting = (state != ST_INIT);
  assign post      = (state == ST_POST) && (!res_valid || m_tready);

  always_comb begin
    state_next    = state;
    cur_row_next  = cur_row;
    cur_col_next  = cur_col;
    cnt_next      = cnt;
    wr_addr_next  = wr_addr;
    wr_pend_next  = wr_pend;
    data_sel_next = data_sel;
    cmd_pop       = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = cnt;
    mem_wdata     = {attr, BLANK_CHAR};
    mem_re        = 1'b0;
    mem_raddr     = sel_lin[ADDR_W-1:0];
    case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_wdata = {RESET_ATTR, BLANK_CHAR};
        if (cnt == LAST_A) begin
          state_next = ST_IDLE;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop       = 1'b1;
          data_sel_next = 1'b0;
          state_next    = ST_POST;
          case (cmd.kind)
            K_BACKSPACE: begin
              cur_row_next = bs_row;
              cur_col_next = bs_col;
              mem_we       = 1'b1;
              mem_waddr    = bs_lin[ADDR_W-1:0];
            end
            K_PUT_AT: begin
              mem_we    = cmd.on_screen;
              mem_waddr = sel_lin[ADDR_W-1:0];
              mem_wdata = {attr, cmd.char_code};
            end
            K_READ: begin
              mem_re        = cmd.on_screen;
              data_sel_next = cmd.on_screen;
            end
            K_CLEAR: begin
              cur_row_next = '0;
              cur_col_next = '0;
              cnt_next     = '0;
              state_next   = ST_FILL;
            end
            default: begin
              if (cmd.kind == K_TTY_CHAR) begin
                mem_we    = 1'b1;
                mem_waddr = cur_lin[ADDR_W-1:0];
                mem_wdata = {attr, cmd.char_code};
              end
              cur_col_next = adv_col[6:0];
              if (adv_row >= 6'(SCREEN_ROWS)) begin
                cur_row_next = 5'(SCREEN_ROWS - 1);
                cnt_next     = '0;
                wr_pend_next = 1'b0;
                state_next   = ST_SCROLL;
              end else begin
                cur_row_next = adv_row[4:0];
              end
            end
          endcase
        end
      end
      ST_SCROLL: begin
        mem_we    = wr_pend;
        mem_waddr = wr_addr;
        mem_wdata = rd_data;
        if (cnt != COPY_END_A) begin
          mem_re       = 1'b1;
          mem_raddr    = cnt + COLS_A;
          wr_addr_next = cnt;
          wr_pend_next = 1'b1;
          cnt_next     = cnt + 1'b1;
        end else begin
          wr_pend_next = 1'b0;
          state_next   = ST_FILL;
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
        if (cnt == LAST_A) begin
          state_next = ST_POST;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end
      ST_POST: begin
        if (post) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_INIT;
      cur_row  <= '0;
      cur_col  <= '0;
      cnt      <= '0;
      wr_pend  <= 1'b0;
      data_sel <= 1'b0;
      attr     <= RESET_ATTR;
    end else begin
      state    <= state_next;
      cur_row  <= cur_row_next;
      cur_col  <= cur_col_next;
      cnt      <= cnt_next;
      wr_pend  <= wr_pend_next;
      data_sel <= data_sel_next;
      if (cfg_we) begin
        attr <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    wr_addr <= wr_addr_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (post) begin
      res_valid <= 1'b1;
    end else if (m_tready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (post) begin
      res_pos  <= cur_lin[10:0];
      res_data <= data_sel ? rd_data : 16'd0;
    end
  end

  assign m_tvalid        = res_valid;
  assign cursor_position = res_pos;
  assign cell_data       = res_data;

  `TCT_ASSERT(a_cursor_on_screen, clk, rst, (({1'b0, cur_row} < 6'(SCREEN_ROWS)) && ({1'b0, cur_col} < 8'(SCREEN_COLUMNS))), "cursor left the screen")
  `TCT_ASSERT(a_result_from_post, clk, rst, ($rose(res_valid) |-> $past(state) == ST_POST), "result raised outside post")
  `TCT_ASSERT_ALWAYS(a_pop_in_idle, clk, (cmd_pop |-> (state == ST_IDLE && cmd_valid)), "command taken while busy")
  `TCT_ASSERT(a_no_write_in_post, clk, rst, ((state == ST_POST) |-> !mem_we), "screen written while posting")

endmodule

// ===== rtl/core/text_console_teletype_top.sv =====
// ordinary items: queued, so new input beats are taken while the back engine is busy
// the back engine executes one command at a time, then the result register is loaded
// scroll copies each row up by one row, then fills the last row with blanks
// clear fills the whole screen with blanks; the screen ram has one write port
// reset: cursor homed, attribute 7, then a blanking pass over every cell
// during which s_tready stays low; configuration writes are taken throughout
module text_console_teletype_top #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // opcode, char_code, row_select, column_select
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // cursor_position, cell_data
);
  import tct_pkg::*;

  logic        enable;
  logic        full;
  logic        push;
  cmd_t        push_cmd;
  logic        cmd_valid;
  logic        cmd_pop;
  cmd_t        cmd;
  logic [10:0] cursor_position;
  logic [15:0] cell_data;

  tct_front #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_front (
    .enable  (enable),
    .full    (full),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .push    (push),
    .cmd     (push_cmd)
  );

  tct_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (cmd_pop),
    .cmd_valid(cmd_valid),
    .cmd      (cmd)
  );

  tct_back #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop),
    .accepting      (enable),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .cursor_position(cursor_position),
    .cell_data      (cell_data)
  );

  assign m_tdata = {5'b0, cell_data, cursor_position};

endmodule
